@@ src/rle_hue_pkg.sv @@
// Shared types, codes and constants for the run-length sprite row decoder.
// No dependencies; imported by rle_sprite_row_decoder_with_hue.
package rle_hue_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int HUE_ENTRIES = 32;

   localparam int WIDTH_W = 11;              // image_width register
   localparam int POS_W   = 17;              // column and run end, saturating
   localparam int WORD_W  = 16;
   localparam int ROW_W   = 10;
   localparam int X_W     = 10;
   localparam int CHAN_W  = 8;
   localparam int HUE_W   = 3 * CHAN_W;
   localparam int SLOT_W  = $clog2(HUE_ENTRIES);
   localparam int CMD_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = WIDTH_W;

   localparam logic [POS_W-1:0]   POS_MAX       = {POS_W{1'b1}};
   localparam logic [WIDTH_W-1:0] MAX_WIDTH_VAL = WIDTH_W'(MAX_WIDTH);
   localparam logic [WIDTH_W-1:0] WIDTH_RESET   = WIDTH_W'(44);

   typedef logic [CMD_W-1:0] cmd_type;
   localparam cmd_type CMD_LOAD_HUE  = 2'd0;
   localparam cmd_type CMD_BEGIN_ROW = 2'd1;
   localparam cmd_type CMD_DATA      = 2'd2;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_HUE_ENABLE  = 2'd0;
   localparam csr_idx_type CSR_PARTIAL_HUE = 2'd1;
   localparam csr_idx_type CSR_IMAGE_WIDTH = 2'd2;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_SKIP   = 4'b0010,
      PH_LEN    = 4'b0100,
      PH_COLOUR = 4'b1000
   } phase_type;

   localparam logic KIND_PIXEL   = 1'b0;
   localparam logic KIND_ROW_END = 1'b1;

   typedef logic [HUE_W-1:0] hue_entry_type;

   // add that clamps at the top of the position range
   function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
      logic [POS_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[POS_W] ? POS_MAX : sum[POS_W-1:0];
   endfunction

endpackage

@@ src/rle_sprite_row_decoder_with_hue.sv @@
// Run-length sprite row decoder with RGB555 to RGB888 expansion and hue table.
// Depends on rle_hue_pkg.
//
// Takes one transaction per clock unless req_stall is high: commands load a
// hue entry, begin a row, or feed a stream word (skip, run length, colour).
// Each transaction is parsed combinationally from the phase register, the
// column and run-end adders and a read of the 32-entry flip-flop hue table,
// and any result (a pixel or a row end) lands in the result register in the
// cycle after acceptance. Sustained rate is one transaction per cycle while
// req_stall is low; it rises only while the consumer stalls a held result.
module rle_sprite_row_decoder_with_hue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  rle_hue_pkg::csr_idx_type      csr_index,
   input  logic [rle_hue_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rle_hue_pkg::cmd_type          req_command,
   input  logic [rle_hue_pkg::WORD_W-1:0] req_data_word,
   input  logic [rle_hue_pkg::ROW_W-1:0] req_row_number,
   input  logic [rle_hue_pkg::SLOT_W-1:0] req_hue_slot,
   input  logic [rle_hue_pkg::CHAN_W-1:0] req_hue_red,
   input  logic [rle_hue_pkg::CHAN_W-1:0] req_hue_green,
   input  logic [rle_hue_pkg::CHAN_W-1:0] req_hue_blue,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_kind,
   output logic [rle_hue_pkg::X_W-1:0]   rsp_pixel_x,
   output logic [rle_hue_pkg::ROW_W-1:0] rsp_pixel_y,
   output logic [rle_hue_pkg::CHAN_W-1:0] rsp_red,
   output logic [rle_hue_pkg::CHAN_W-1:0] rsp_green,
   output logic [rle_hue_pkg::CHAN_W-1:0] rsp_blue
);
   import rle_hue_pkg::*;

   // configuration
   logic               hue_enable_ff;
   logic               partial_hue_ff;
   logic [WIDTH_W-1:0] image_width_ff;

   // parse state
   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   column_ff, column_in;
   logic [POS_W-1:0]   run_end_ff, run_end_in;
   logic [WORD_W-1:0]  skip_ff, skip_in;
   logic [ROW_W-1:0]   row_ff, row_in;

   hue_entry_type      hue_table_ff [HUE_ENTRIES];

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [X_W-1:0]     rsp_x_ff, rsp_x_in;
   logic [CHAN_W-1:0]  rsp_red_ff, rsp_red_in;
   logic [CHAN_W-1:0]  rsp_green_ff, rsp_green_in;
   logic [CHAN_W-1:0]  rsp_blue_ff, rsp_blue_in;
   logic [ROW_W-1:0]   rsp_y_ff;

   logic               accept;
   logic               emit;
   logic [WIDTH_W-1:0] width_eff;
   logic [POS_W-1:0]   width_pos;
   logic [POS_W-1:0]   col_skip;
   logic [POS_W-1:0]   col_step;
   logic [POS_W-1:0]   run_new;
   logic [SLOT_W-1:0]  hue_idx;
   logic [CHAN_W-1:0]  exp_r, exp_g, exp_b;
   hue_entry_type      hue_rd;
   logic               use_hue;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign width_eff = (image_width_ff > MAX_WIDTH_VAL) ? MAX_WIDTH_VAL : image_width_ff;
   assign width_pos = POS_W'(width_eff);

   assign col_skip = sat_add(column_ff, POS_W'(skip_ff));
   assign run_new  = sat_add(col_skip, POS_W'(req_data_word));
   assign col_step = sat_add(column_ff, POS_W'(1));

   // RGB555 expansion; bit fifteen is ignored
   assign hue_idx = req_data_word[14:10];
   assign exp_r   = {req_data_word[14:10], 3'b000};
   assign exp_g   = {req_data_word[9:5], 3'b000};
   assign exp_b   = {req_data_word[4:0], 3'b000};
   assign hue_rd  = hue_table_ff[hue_idx];
   assign use_hue = hue_enable_ff && (!partial_hue_ff ||
                    (req_data_word[14:10] == req_data_word[9:5] &&
                     req_data_word[9:5] == req_data_word[4:0]));

   always_comb begin
      phase_in     = phase_ff;
      column_in    = column_ff;
      run_end_in   = run_end_ff;
      skip_in      = skip_ff;
      row_in       = row_ff;
      emit         = 1'b0;
      rsp_kind_in  = KIND_ROW_END;
      rsp_x_in     = '0;
      rsp_red_in   = '0;
      rsp_green_in = '0;
      rsp_blue_in  = '0;

      case (req_command)
         CMD_LOAD_HUE: begin
         end
         CMD_BEGIN_ROW: begin
            row_in     = req_row_number;
            column_in  = '0;
            run_end_in = '0;
            skip_in    = '0;
            phase_in   = PH_SKIP;
         end
         CMD_DATA: begin
            case (phase_ff)
               PH_SKIP: begin
                  if (column_ff >= width_pos) begin
                     emit     = 1'b1;
                     phase_in = PH_IDLE;
                  end else begin
                     skip_in  = req_data_word;
                     phase_in = PH_LEN;
                  end
               end
               PH_LEN: begin
                  if (skip_ff == '0 && req_data_word == '0) begin
                     emit     = 1'b1;
                     phase_in = PH_IDLE;
                  end else begin
                     column_in  = col_skip;
                     run_end_in = run_new;
                     if (col_skip >= run_new) begin
                        // empty run: either the width is reached or the next pair follows
                        if (col_skip >= width_pos) begin
                           emit     = 1'b1;
                           phase_in = PH_IDLE;
                        end else begin
                           phase_in = PH_SKIP;
                        end
                     end else begin
                        phase_in = PH_COLOUR;
                     end
                  end
               end
               PH_COLOUR: begin
                  column_in = col_step;
                  if (col_step >= run_end_ff) begin
                     phase_in = PH_SKIP;
                  end
                  if (req_data_word != '0 && column_ff < width_pos) begin
                     emit        = 1'b1;
                     rsp_kind_in = KIND_PIXEL;
                     rsp_x_in    = column_ff[X_W-1:0];
                     if (use_hue) begin
                        rsp_red_in   = hue_rd[HUE_W-1 -: CHAN_W];
                        rsp_green_in = hue_rd[CHAN_W +: CHAN_W];
                        rsp_blue_in  = hue_rd[CHAN_W-1:0];
                     end else begin
                        rsp_red_in   = exp_r;
                        rsp_green_in = exp_g;
                        rsp_blue_in  = exp_b;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = (accept && emit) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_enable_ff  <= 1'b0;
         partial_hue_ff <= 1'b0;
         image_width_ff <= WIDTH_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_HUE_ENABLE:  hue_enable_ff  <= csr_wdata[0];
            CSR_PARTIAL_HUE: partial_hue_ff <= csr_wdata[0];
            CSR_IMAGE_WIDTH: image_width_ff <= csr_wdata[WIDTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         column_ff    <= '0;
         run_end_ff   <= '0;
         skip_ff      <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff   <= phase_in;
            column_ff  <= column_in;
            run_end_ff <= run_end_in;
            skip_ff    <= skip_in;
            row_ff     <= row_in;
         end
      end
   end

   // hue table: no reset; the user must load an entry before it is read, the block does not enforce it
   always_ff @(posedge clock) begin
      if (accept && req_command == CMD_LOAD_HUE) begin
         hue_table_ff[req_hue_slot] <= {req_hue_red, req_hue_green, req_hue_blue};
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_x_ff     <= rsp_x_in;
         rsp_y_ff     <= row_ff;
         rsp_red_ff   <= rsp_red_in;
         rsp_green_ff <= rsp_green_in;
         rsp_blue_ff  <= rsp_blue_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_pixel_x = rsp_x_ff;
   assign rsp_pixel_y = rsp_y_ff;
   assign rsp_red     = rsp_red_ff;
   assign rsp_green   = rsp_green_ff;
   assign rsp_blue    = rsp_blue_ff;

endmodule
